/* rtl/ppg_pkg.sv */
// Shared types, constants and microcode program for the pulse peak heart-rate block.
// No dependencies; every other file imports this package.
package ppg_pkg;

   // Window geometry and arithmetic constants
   localparam int WIN        = 7;
   localparam int CENTRE     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 8;
   localparam int REFR_W     = 16;
   localparam int QUO_W      = 8;
   localparam int DIVIDEND_W = 16;
   localparam int PC_W       = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIVIDEND_W-1:0] MS_PER_MIN       = 16'd60000;
   localparam logic [REFR_W-1:0]     REFRACTORY_RESET = 16'd425;
   // largest gap whose estimate saturates at full scale
   localparam int                    SAT_GAP          = 234;
   localparam logic [RATE_W-1:0]     RATE_MAX         = 8'hFF;

   // register index within the config space
   localparam logic REG_REFRACTORY = 1'b0;

   typedef enum logic [3:0] {
      OP_NOP  = 4'd0,
      OP_WAIT = 4'd1,
      OP_TEST = 4'd2,
      OP_DIV  = 4'd3,
      OP_PUSH = 4'd4,
      OP_ACC  = 4'd5,
      OP_RATE = 4'd6,
      OP_EMIT = 4'd7
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT      = 3'd0,
      COND_GOTO      = 3'd1,
      COND_ACCEPT    = 3'd2,
      COND_LOOP      = 3'd3,
      COND_SKIP_PEAK = 3'd4,
      COND_SKIP_FULL = 3'd5,
      COND_EMIT      = 3'd6
   } cond_type;

   typedef enum logic [1:0] {
      CNT_KEEP = 2'd0,
      CNT_DIV  = 2'd1,
      CNT_AVG  = 2'd2
   } cnt_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      cnt_type           cnt;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic accept;
      logic no_peak;
      logic not_full;
      logic out_free;
   } useq_status_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
   localparam logic [PC_W-1:0] PC_TEST = 4'd1;
   localparam logic [PC_W-1:0] PC_EST  = 4'd2;
   localparam logic [PC_W-1:0] PC_PUSH = 4'd3;
   localparam logic [PC_W-1:0] PC_ACC  = 4'd4;
   localparam logic [PC_W-1:0] PC_RATE = 4'd5;
   localparam logic [PC_W-1:0] PC_EMIT = 4'd6;

   // microcode ROM
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_GOTO, cnt: CNT_KEEP, target: PC_WAIT};
      case (addr)
         PC_WAIT: w = '{op: OP_WAIT, cond: COND_ACCEPT,    cnt: CNT_KEEP, target: PC_WAIT};
         PC_TEST: w = '{op: OP_TEST, cond: COND_SKIP_PEAK, cnt: CNT_DIV,  target: PC_EMIT};
         PC_EST:  w = '{op: OP_DIV,  cond: COND_LOOP,      cnt: CNT_KEEP, target: PC_WAIT};
         PC_PUSH: w = '{op: OP_PUSH, cond: COND_SKIP_FULL, cnt: CNT_AVG,  target: PC_EMIT};
         PC_ACC:  w = '{op: OP_ACC,  cond: COND_LOOP,      cnt: CNT_KEEP, target: PC_WAIT};
         PC_RATE: w = '{op: OP_RATE, cond: COND_NEXT,      cnt: CNT_KEEP, target: PC_WAIT};
         PC_EMIT: w = '{op: OP_EMIT, cond: COND_EMIT,      cnt: CNT_KEEP, target: PC_WAIT};
         default: w = '{op: OP_NOP,  cond: COND_GOTO,      cnt: CNT_KEEP, target: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

/* rtl/ppg_peak_heart_rate_top.sv */
// Top level of the pulse peak heart-rate block: ports, datapath, config register.
// Depends on ppg_pkg, ppg_useq and ppg_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample, req_time_ms
//   rsp      out        rsp_valid/rsp_stall  rsp_heart_rate
//   csr      in/out     APB psel/penable     refractory_ms at byte address 0
//
// An item passes the wait and test steps and goes on to the emit step when no
// peak counts. A counted peak runs the eight-step divider for the estimate and
// pushes it onto the list; once the list is full, an accumulate at one estimate
// per cycle sums the list, and a combinational multiply takes the mean as rate.
// Reset is synchronous, active high, and clears window, peak time, estimates
// and rate. A stalled result holds in the output register; the next
// transaction is still taken and held in the emit step until that one leaves.
module ppg_peak_heart_rate_top #(
   parameter int AVERAGE_DEPTH = 7,
   parameter int TIME_BITS     = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input transactions
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ppg_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [31:0]                       req_time_ms,
   // result transactions
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ppg_pkg::RATE_W-1:0]        rsp_heart_rate,
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ppg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ppg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ppg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import ppg_pkg::*;

   localparam int COUNT_W    = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W      = $clog2(AVERAGE_DEPTH * 255 + 1);
   // mean = sum * ceil(2^MEAN_SHIFT / depth) >> MEAN_SHIFT, exact while
   // sum * (depth - 1) stays below 2^MEAN_SHIFT
   localparam int MEAN_SHIFT = 24;
   localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
   localparam int PROD_W     = SUM_W + MEAN_SHIFT + 1;

   // window and peak state
   logic [SAMPLE_W-1:0]  sample_win_ff [WIN];
   logic [SAMPLE_W-1:0]  sample_win_in [WIN];
   logic [TIME_BITS-1:0] time_win_ff   [WIN];
   logic [TIME_BITS-1:0] time_win_in   [WIN];
   logic [TIME_BITS-1:0] last_peak_ff, last_peak_in;

   // estimate list and averaging
   logic [RATE_W-1:0]    est_ff [AVERAGE_DEPTH];
   logic [RATE_W-1:0]    est_in [AVERAGE_DEPTH];
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 sat_ff, sat_in;
   logic [RATE_W-1:0]    held_ff, held_in;

   // config and output registers
   logic [REFR_W-1:0]    refr_ff, refr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;

   op_type               op;
   useq_status_type      status;
   logic                 accept;
   logic                 out_free;
   logic                 peak;
   logic                 counted;
   logic [TIME_BITS-1:0] gap;
   logic                 div_load;
   logic                 div_step;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [TIME_BITS-1:0] div_divisor;
   logic [QUO_W-1:0]     quotient;
   logic [RATE_W-1:0]    est_new;
   logic [PROD_W-1:0]    mean_prod;
   logic [RATE_W-1:0]    mean_rate;
   logic                 csr_write;

   // handshakes
   assign req_stall = (op != OP_WAIT);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // peak test on the centre of the window
   always_comb begin
      peak = (sample_win_ff[CENTRE] >= sample_win_ff[1]) &&
             (sample_win_ff[CENTRE] >= sample_win_ff[2]) &&
             (sample_win_ff[CENTRE] >= sample_win_ff[4]) &&
             (sample_win_ff[CENTRE] >= sample_win_ff[5]) &&
             (sample_win_ff[CENTRE] >  sample_win_ff[0]) &&
             (sample_win_ff[CENTRE] >  sample_win_ff[6]);
      gap     = time_win_ff[CENTRE] - last_peak_ff;
      counted = peak && (gap > TIME_BITS'(refr_ff));
   end

   always_comb begin
      status.accept   = accept;
      status.no_peak  = !counted;
      status.not_full = count_ff < COUNT_W'(AVERAGE_DEPTH - 1);
      status.out_free = out_free;
   end

   // divider: estimate 60000 / gap
   assign div_load     = (op == OP_TEST);
   assign div_step     = (op == OP_DIV);
   assign div_dividend = MS_PER_MIN;
   assign div_divisor  = gap;
   assign est_new      = sat_ff ? RATE_MAX : quotient;

   // mean of the estimate list by reciprocal multiply
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(MEAN_RECIP);
   assign mean_rate = mean_prod[MEAN_SHIFT +: RATE_W];

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == REG_REFRACTORY);

   always_comb begin
      sample_win_in = sample_win_ff;
      time_win_in   = time_win_ff;
      last_peak_in  = last_peak_ff;
      est_in        = est_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      sat_in        = sat_ff;
      held_in       = held_ff;
      refr_in       = csr_write ? csr_pwdata[REFR_W-1:0] : refr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rate_in   = rsp_rate_ff;

      unique case (op)
         OP_WAIT: begin
            // shift the new sample into the window
            if (accept) begin
               for (int i = 0; i < WIN - 1; i++) begin
                  sample_win_in[i] = sample_win_ff[i+1];
                  time_win_in[i]   = time_win_ff[i+1];
               end
               sample_win_in[WIN-1] = req_sample;
               time_win_in[WIN-1]   = req_time_ms[TIME_BITS-1:0];
            end
         end
         OP_TEST: begin
            sat_in = gap <= TIME_BITS'(SAT_GAP);
            if (counted) begin
               last_peak_in = time_win_ff[CENTRE];
            end
         end
         OP_PUSH: begin
            // drop the oldest estimate, append the new one
            for (int i = 0; i < AVERAGE_DEPTH - 1; i++) begin
               est_in[i] = est_ff[i+1];
            end
            est_in[AVERAGE_DEPTH-1] = est_new;
            if (count_ff < COUNT_W'(AVERAGE_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end
            sum_in = '0;
         end
         OP_ACC: begin
            // rotate the list once around, summing the head
            sum_in = sum_ff + SUM_W'(est_ff[0]);
            for (int i = 0; i < AVERAGE_DEPTH - 1; i++) begin
               est_in[i] = est_ff[i+1];
            end
            est_in[AVERAGE_DEPTH-1] = est_ff[0];
         end
         OP_RATE: held_in = mean_rate;
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = held_ff;
            end
         end
         OP_NOP, OP_DIV: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            sample_win_ff[i] <= '0;
            time_win_ff[i]   <= '0;
         end
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            est_ff[i] <= '0;
         end
         last_peak_ff <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         refr_ff      <= REFRACTORY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         sample_win_ff <= sample_win_in;
         time_win_ff   <= time_win_in;
         est_ff        <= est_in;
         last_peak_ff  <= last_peak_in;
         count_ff      <= count_in;
         held_ff       <= held_in;
         refr_ff       <= refr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      sat_ff      <= sat_in;
      rsp_rate_ff <= rsp_rate_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_heart_rate = rsp_rate_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = (csr_paddr[2] == REG_REFRACTORY) ?
                           CSR_DATA_W'(refr_ff) : '0;

   ppg_useq #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   ppg_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient)
   );

`ifndef ASSERT_OFF
   // one transaction at a time: the sequencer leaves the wait step on accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input taken again right after a transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(AVERAGE_DEPTH))
      else $error("estimate count beyond list depth");

   a_peak_time: assert property (@(posedge clock) disable iff (reset)
      (op == OP_TEST && counted) |=> last_peak_ff == $past(time_win_ff[CENTRE]))
      else $error("counted peak time not recorded");

   a_rate_full: assert property (@(posedge clock) disable iff (reset)
      !$stable(held_ff) |-> count_ff == COUNT_W'(AVERAGE_DEPTH))
      else $error("rate updated before estimate list filled");
`endif

endmodule

/* rtl/ppg_div.sv */
// Restoring divider, one quotient bit per step, eight-bit quotient.
// Depends on ppg_pkg.
module ppg_div #(
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              step,
   input  logic [ppg_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [TIME_BITS-1:0]              divisor,
   output logic [ppg_pkg::QUO_W-1:0]         quotient
);
   import ppg_pkg::*;

   localparam int DSH_W = TIME_BITS + QUO_W - 1;

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0]      dsh_ff, dsh_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [DSH_W-1:0]      rem_ext;
   logic [DSH_W-1:0]      diff;
   logic                  fits;

   always_comb begin
      rem_ext = DSH_W'(rem_ff);
      fits    = rem_ext >= dsh_ff;
      diff    = rem_ext - dsh_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (load) begin
         rem_in = dividend;
         dsh_in = DSH_W'(divisor) << (QUO_W - 1);
         quo_in = '0;
      end else if (step) begin
         if (fits) begin
            rem_in = diff[DIVIDEND_W-1:0];
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

/* rtl/ppg_useq.sv */
// Microcode sequencer: program counter, loop counter and jump logic over the ROM.
// Depends on ppg_pkg.
module ppg_useq #(
   parameter int AVERAGE_DEPTH = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ppg_pkg::useq_status_type  status,
   output ppg_pkg::op_type           op
);
   import ppg_pkg::*;

   localparam int LOOP_MAX = (AVERAGE_DEPTH > QUO_W) ? AVERAGE_DEPTH : QUO_W;
   localparam int CNT_W    = $clog2(LOOP_MAX);

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PC_W-1:0]  pc_inc;
   ucode_type        word;

   always_comb begin
      word   = ucode_rom(pc_ff);
      pc_inc = pc_ff + 1'b1;
      pc_in  = pc_ff;
      cnt_in = cnt_ff;
      unique case (word.cond)
         COND_NEXT:      pc_in = pc_inc;
         COND_GOTO:      pc_in = word.target;
         COND_ACCEPT:    pc_in = status.accept ? pc_inc : pc_ff;
         COND_LOOP: begin
            if (cnt_ff == '0) begin
               pc_in = pc_inc;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         COND_SKIP_PEAK: pc_in = status.no_peak ? word.target : pc_inc;
         COND_SKIP_FULL: pc_in = status.not_full ? word.target : pc_inc;
         COND_EMIT:      pc_in = status.out_free ? word.target : pc_ff;
         default:        pc_in = word.target;
      endcase
      unique case (word.cnt)
         CNT_KEEP: ;
         CNT_DIV:  cnt_in = CNT_W'(QUO_W - 1);
         CNT_AVG:  cnt_in = CNT_W'(AVERAGE_DEPTH - 1);
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PC_WAIT;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign op = word.op;

endmodule
